FILE: src/bfrc_pkg.sv
// Shared types and constants for the banked FIFO-replacement region cache.
`timescale 1ns / 1ps
`default_nettype none

package bfrc_pkg;

    // Field widths fixed by the interface
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned PAY_PORT_W = 32;
    localparam int unsigned COUNT_W    = 32;

    // Boundary accumulator: up to 32 bands of 65535
    localparam int unsigned BOUND_W    = 21;

    localparam logic [COORD_W-1:0] WIDTH_RESET = 16'd640;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } bfrc_op_t;

    // Controller -> datapath
    typedef struct packed {
        logic ld_item;
        logic div_init;
        logic bank_init;
        logic bank_step;
        logic scan_init;
        logic scan_run;
        logic wr_entry;
        logic finish;
    } bfrc_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       bank_done;
        logic       match;
        logic       scan_end;
        logic       out_free;
    } bfrc_stat_t;

endpackage

`default_nettype wire

FILE: src/banked_fifo_replacement_cache.sv
// Top level of the banked FIFO-replacement region cache.
//
//  channel | signals                                   | direction | beat when
//  --------+-------------------------------------------+-----------+-------------------
//  cfg     | cfg_we, cfg_wdata (image_width)           | in        | cfg_we high
//  in      | in_valid/in_ready, command, region_x/y/w/h | in        | valid & ready
//          | payload_in                                |           |
//  out     | out_valid/out_ready, hit, already_present,| out       | valid & ready
//          | payload_out, hits_total, misses_total     |           |
//
// Steps per beat: clear and the unused code go from the accept straight to the result.
//   Lookup and insert first size the band, walk the bank boundaries to the chosen bank
//   and scan its slots up to a match; an insert that fills a slot adds a write step.
// The band size is a constant reciprocal multiply, and the one read port of the entry
//   RAM scans one slot a cycle.
// Reset: asynchronous, active low; all valid bits, FIFO pointers and totals clear at
//   once, image_width returns to 640. RAM contents are only read behind a valid bit.
// Stalls: the result sits in an output register, so a new beat is accepted while it
//   waits; the next result only loads once that register is free.
`timescale 1ns / 1ps
`default_nettype none

module banked_fifo_replacement_cache
    import bfrc_pkg::*;
#(
    parameter int unsigned NUM_BUCKETS        = 4,
    parameter int unsigned ENTRIES_PER_BUCKET = 16,
    parameter int unsigned PAYLOAD_BITS       = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration
    input  wire logic                  cfg_we,
    input  wire logic [COORD_W-1:0]    cfg_wdata,
    // Request beat
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            command,
    input  wire logic [COORD_W-1:0]    region_x,
    input  wire logic [COORD_W-1:0]    region_y,
    input  wire logic [COORD_W-1:0]    region_w,
    input  wire logic [COORD_W-1:0]    region_h,
    input  wire logic [PAY_PORT_W-1:0] payload_in,
    // Result beat
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       hit,
    output logic                       already_present,
    output logic [PAY_PORT_W-1:0]      payload_out,
    output logic [COUNT_W-1:0]         hits_total,
    output logic [COUNT_W-1:0]         misses_total
);

    bfrc_cmd_t  cmd;
    bfrc_stat_t stat;

    // Sequencer: accepts a beat only in idle, then steps the datapath
    bfrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (command),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: key/payload store, band size, bank walk, slot scan, totals
    bfrc_dp #(
        .NUM_BUCKETS        (NUM_BUCKETS),
        .ENTRIES_PER_BUCKET (ENTRIES_PER_BUCKET),
        .PAYLOAD_BITS       (PAYLOAD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .command         (command),
        .region_x        (region_x),
        .region_y        (region_y),
        .region_w        (region_w),
        .region_h        (region_h),
        .payload_in      (payload_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hit             (hit),
        .already_present (already_present),
        .payload_out     (payload_out),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .cmd             (cmd),
        .stat            (stat)
    );

`ifndef SYNTHESIS
    // One beat at a time: after an accept the request side closes
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while a beat is still in work");

    // A result never reports both a lookup hit and a skipped insert
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && already_present))
        else $error("hit and already_present both set");

    // Totals only move when a new result is loaded, and never go down
    assert property (@(posedge clk) disable iff (!rst_n)
        (hits_total != $past(hits_total)) || (misses_total != $past(misses_total))
        |-> out_valid && (hits_total >= $past(hits_total))
            && (misses_total >= $past(misses_total)))
        else $error("totals changed outside a result load");
`endif

endmodule

`default_nettype wire

FILE: src/bfrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bfrc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/bfrc_ctrl.sv
// Sequencer for the region cache: divide, pick bank, scan, write, report.
`timescale 1ns / 1ps
`default_nettype none

module bfrc_ctrl
    import bfrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_op,
    output logic            in_ready,
    input  wire bfrc_stat_t stat,
    output bfrc_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_INIT,
        S_BANK_INIT,
        S_BANK,
        S_SCAN,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_next;
    logic   in_ready_reg;

    assign in_ready = in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_item = 1'b1;
                    if (in_op == OP_LOOKUP || in_op == OP_INSERT)
                    begin
                        state_next = S_DIV_INIT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_BANK_INIT;
            end
            S_BANK_INIT:
            begin
                cmd.bank_init = 1'b1;
                state_next    = S_BANK;
            end
            S_BANK:
            begin
                if (stat.bank_done)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    cmd.bank_step = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.match)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.scan_end)
                begin
                    state_next = (stat.op == OP_INSERT) ? S_WRITE : S_FINISH;
                end
            end
            S_WRITE:
            begin
                cmd.wr_entry = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready_next = (state_next == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/bfrc_dp.sv
// Datapath: item registers, band reciprocal, bank select, slot scan, counters.
`timescale 1ns / 1ps
`default_nettype none

module bfrc_dp
    import bfrc_pkg::*;
#(
    parameter int unsigned NUM_BUCKETS        = 4,
    parameter int unsigned ENTRIES_PER_BUCKET = 16,
    parameter int unsigned PAYLOAD_BITS       = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [COORD_W-1:0]    cfg_wdata,
    input  wire logic [1:0]            command,
    input  wire logic [COORD_W-1:0]    region_x,
    input  wire logic [COORD_W-1:0]    region_y,
    input  wire logic [COORD_W-1:0]    region_w,
    input  wire logic [COORD_W-1:0]    region_h,
    input  wire logic [PAY_PORT_W-1:0] payload_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       hit,
    output logic                       already_present,
    output logic [PAY_PORT_W-1:0]      payload_out,
    output logic [COUNT_W-1:0]         hits_total,
    output logic [COUNT_W-1:0]         misses_total,
    input  wire bfrc_cmd_t             cmd,
    output bfrc_stat_t                 stat
);

    localparam int unsigned DEPTH   = NUM_BUCKETS * ENTRIES_PER_BUCKET;
    localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SLOT_W  = (ENTRIES_PER_BUCKET > 1) ?
                                      $clog2(ENTRIES_PER_BUCKET) : 1;
    localparam int unsigned BANK_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int unsigned STORE_W = (PAYLOAD_BITS < PAY_PORT_W) ?
                                      PAYLOAD_BITS : PAY_PORT_W;
    localparam int unsigned WORD_W  = KEY_W + STORE_W;

    // width / NUM_BUCKETS as a multiply by a rounded-up reciprocal; with
    // 16 + ceil(log2 N) fraction bits the quotient is exact for any 16-bit width
    localparam int unsigned DIV_SH  = COORD_W + ((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 0);
    localparam int unsigned PROD_W  = DIV_SH + COORD_W;
    localparam logic [PROD_W-1:0] RECIP =
        PROD_W'(((1 << DIV_SH) + NUM_BUCKETS - 1) / NUM_BUCKETS);

    localparam logic [SLOT_W-1:0]      LAST_SLOT = SLOT_W'(ENTRIES_PER_BUCKET - 1);
    localparam logic [BANK_W-1:0]      LAST_BANK = BANK_W'(NUM_BUCKETS - 1);

    // Item registers
    logic [1:0]          op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [STORE_W-1:0]  pay_reg;
    logic [COORD_W-1:0]  width_reg;

    // Band size
    logic [PROD_W-1:0]    band_prod;
    logic [COORD_W-1:0]   quo_reg;

    // Bank select
    logic [BANK_W-1:0]  bank_reg;
    logic [BOUND_W-1:0] bound_reg;

    // Slot scan
    logic [SLOT_W-1:0]  iss_reg;
    logic               iss_done_reg;
    logic               issue;
    logic               cmp_vld_reg;
    logic               cmp_last_reg;
    logic               cmp_ok_reg;
    logic               found_reg;
    logic [STORE_W-1:0] fpay_reg;
    logic               match;

    // Storage
    logic [DEPTH-1:0]   valid_reg;
    logic [SLOT_W-1:0]  ptr_reg [NUM_BUCKETS];
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  rdata;

    // Results
    logic                  out_valid_reg;
    logic                  hit_reg;
    logic                  present_reg;
    logic [PAY_PORT_W-1:0] pay_out_reg;
    logic [COUNT_W-1:0]    hit_cnt_reg;
    logic [COUNT_W-1:0]    miss_cnt_reg;
    logic                  res_hit;
    logic                  res_present;

    assign band_prod = PROD_W'(width_reg) * RECIP;
    assign issue   = cmd.scan_run && !iss_done_reg;
    assign rd_addr = ADDR_W'(int'(bank_reg) * ENTRIES_PER_BUCKET + int'(iss_reg));
    assign wr_addr = ADDR_W'(int'(bank_reg) * ENTRIES_PER_BUCKET
                             + int'(ptr_reg[bank_reg]));
    assign match   = cmp_vld_reg && cmp_ok_reg
                     && (rdata[WORD_W-1:STORE_W] == key_reg);

    assign res_hit     = (op_reg == OP_LOOKUP) && found_reg;
    assign res_present = (op_reg == OP_INSERT) && found_reg;

    assign stat.op        = op_reg;
    assign stat.bank_done = (bank_reg == LAST_BANK)
                            || (BOUND_W'(key_reg[KEY_W-1 -: COORD_W]) < bound_reg);
    assign stat.match     = match;
    assign stat.scan_end  = cmp_vld_reg && cmp_last_reg && !match;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign already_present = present_reg;
    assign payload_out     = pay_out_reg;
    assign hits_total      = hit_cnt_reg;
    assign misses_total    = miss_cnt_reg;

    bfrc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.wr_entry),
        .waddr (wr_addr),
        .wdata ({key_reg, pay_reg}),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // Registers without reset: item, band size, bound, compare and result
    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            op_reg  <= command;
            key_reg <= {region_x, region_y, region_w, region_h};
            pay_reg <= STORE_W'(payload_in);
        end
        if (cmd.div_init)
        begin
            quo_reg <= band_prod[DIV_SH +: COORD_W];
        end
        if (cmd.bank_init)
        begin
            bound_reg <= BOUND_W'(quo_reg);
        end
        else if (cmd.bank_step)
        begin
            bound_reg <= bound_reg + BOUND_W'(quo_reg);
        end
        if (cmd.scan_run)
        begin
            cmp_last_reg <= (iss_reg == LAST_SLOT);
            cmp_ok_reg   <= valid_reg[rd_addr];
            if (match)
            begin
                fpay_reg <= rdata[STORE_W-1:0];
            end
        end
        if (cmd.finish)
        begin
            hit_reg     <= res_hit;
            present_reg <= res_present;
            pay_out_reg <= res_hit ? PAY_PORT_W'(fpay_reg) : '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            bank_reg      <= '0;
            iss_reg       <= '0;
            iss_done_reg  <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            valid_reg     <= '0;
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                ptr_reg[b] <= '0;
            end
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_wdata;
            end

            if (cmd.bank_init)
            begin
                bank_reg <= '0;
            end
            else if (cmd.bank_step)
            begin
                bank_reg <= bank_reg + 1'b1;
            end

            if (cmd.scan_init)
            begin
                iss_reg      <= '0;
                iss_done_reg <= 1'b0;
                cmp_vld_reg  <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                cmp_vld_reg <= issue;
                if (issue)
                begin
                    if (iss_reg == LAST_SLOT)
                    begin
                        iss_done_reg <= 1'b1;
                    end
                    else
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                end
                if (match)
                begin
                    found_reg <= 1'b1;
                end
            end

            // FIFO replacement: fill the oldest slot, advance the pointer
            if (cmd.wr_entry)
            begin
                valid_reg[wr_addr] <= 1'b1;
                ptr_reg[bank_reg]  <= (ptr_reg[bank_reg] == LAST_SLOT) ?
                                      '0 : ptr_reg[bank_reg] + 1'b1;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == OP_LOOKUP)
                begin
                    if (found_reg && (hit_cnt_reg != '1))
                    begin
                        hit_cnt_reg <= hit_cnt_reg + 1'b1;
                    end
                    if (!found_reg && (miss_cnt_reg != '1))
                    begin
                        miss_cnt_reg <= miss_cnt_reg + 1'b1;
                    end
                end
                if (op_reg == OP_CLEAR)
                begin
                    valid_reg <= '0;
                    for (int b = 0; b < NUM_BUCKETS; b++)
                    begin
                        ptr_reg[b] <= '0;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
